@@ sv/tcdb_pkg.sv @@
// ----------------------------------------------------------------------------
// tcdb_pkg
// Types and constants shared by the traction command to DCC bridge.
// ----------------------------------------------------------------------------
package tcdb_pkg;

    localparam int ALIAS_ENTRIES_DEF = 16;

    localparam int ALIAS_W     = 12;
    localparam int NODE_W      = 48;
    localparam int ENTRY_W     = ALIAS_W + NODE_W;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 48;
    localparam int MAG_W       = 24;
    localparam int ACC_W       = 56;

    localparam logic [NODE_W-1:0] PREFIX_MASK      = 48'hFFFF_FFFF_0000;
    localparam logic [15:0]       FULL_SPEED_RESET = 16'd10240;
    localparam logic [31:0]       STEP_SCALE_RESET = 32'd3303014;

    localparam logic [6:0]  MAX_STEP     = 7'd126;
    localparam logic [23:0] MAX_FUNCTION = 24'd28;

    localparam logic [3:0] MIN_LEN_DEF   = 4'd6;
    localparam logic [3:0] MIN_LEN_CMD   = 4'd3;
    localparam logic [3:0] MIN_LEN_SPEED = 4'd5;
    localparam logic [3:0] MIN_LEN_FUNC  = 4'd8;

    localparam logic [7:0] OP_SPEED    = 8'd0;
    localparam logic [7:0] OP_FUNCTION = 8'd1;
    localparam logic [7:0] OP_ESTOP    = 8'd2;

    // half float exponent codes
    localparam logic [4:0] EXP_SPECIAL = 5'h1F;
    localparam logic [4:0] EXP_SAT     = 5'd23;
    localparam logic [4:0] EXP_UNIT    = 5'd9;

    typedef enum logic [1:0] {
        CMD_ALIAS_DEF   = 2'd0,
        CMD_ALIAS_RESET = 2'd1,
        CMD_TRACTION    = 2'd2,
        CMD_UNUSED      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ACT_NONE     = 2'd0,
        ACT_SPEED    = 2'd1,
        ACT_FUNCTION = 2'd2,
        ACT_ESTOP    = 2'd3
    } action_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ENABLE       = 2'd0,
        REG_TRAIN_PREFIX = 2'd1,
        REG_FULL_SPEED   = 2'd2,
        REG_STEP_SCALE   = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [3:0]         payload_length;
        logic [ALIAS_W-1:0] source_alias;
        logic [NODE_W-1:0]  node_id;
        logic [ALIAS_W-1:0] dest_alias;
        logic [7:0]         operation;
        logic [15:0]        speed_half;
        logic [23:0]        function_number;
        logic [15:0]        function_value;
    } in_item_t;

    typedef struct packed {
        logic        handled;
        logic [1:0]  action;
        logic [13:0] dcc_address;
        logic [6:0]  speed_step;
        logic        forward;
        logic [4:0]  function_index;
        logic        function_on;
    } out_item_t;

endpackage

@@ sv/traction_command_to_dcc_bridge.sv @@
// ----------------------------------------------------------------------------
// traction_command_to_dcc_bridge
// Maps bus aliases to node IDs and turns traction commands for DCC train
// nodes into speed, function and emergency stop actions. Each transaction
// that touches the alias table walks the table one entry per cycle through a
// single read port, then runs the speed scaling through one 24x16 multiplier
// in two passes. Such a transaction goes from acceptance through the scan,
// the low and the high multiply pass and the finish state, and the next one
// is taken only once the block is back in idle; transactions that skip the
// table (short definitions, unused command, disabled or short traction
// commands) go from acceptance straight to the finish state. The table has
// valid flops per entry, so it is usable right after reset with no clearing
// pass. Results sit in an output register, so a new transaction may start
// while the previous result waits to be taken.
// ----------------------------------------------------------------------------
module traction_command_to_dcc_bridge
    import tcdb_pkg::*;
#(
    parameter int ALIAS_ENTRIES = ALIAS_ENTRIES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_data
);

    localparam int IDX_W = (ALIAS_ENTRIES > 1) ? $clog2(ALIAS_ENTRIES) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(ALIAS_ENTRIES - 1);
    localparam logic [CNT_W-1:0] ENTRY_COUNT = CNT_W'(ALIAS_ENTRIES);
    localparam logic [ACC_W:0]   ROUND_BIAS  = (ACC_W+1)'(1) << 35;

    // half float magnitude in Q8.16, saturated
    function automatic logic [MAG_W-1:0] half_mag(input logic [15:0] h);
        logic [4:0]       e;
        logic [MAG_W-1:0] m;
        logic [MAG_W-1:0] v;
        e = h[14:10];
        m = {13'b0, 1'b1, h[9:0]};
        if (e == 5'd0)
        begin
            v = {22'b0, h[9:8]};
        end
        else if (e >= EXP_SAT)
        begin
            v = '1;
        end
        else if (e >= EXP_UNIT)
        begin
            v = m << (e - EXP_UNIT);
        end
        else
        begin
            v = m >> (EXP_UNIT - e);
        end
        return v;
    endfunction

    // configuration
    logic              enable_reg;
    logic [NODE_W-1:0] train_prefix_reg;
    logic [15:0]       full_speed_reg;
    logic [31:0]       step_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg       <= 1'b0;
            train_prefix_reg <= '0;
            full_speed_reg   <= FULL_SPEED_RESET;
            step_scale_reg   <= STEP_SCALE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ENABLE:       enable_reg       <= cfg_data[0];
                REG_TRAIN_PREFIX: train_prefix_reg <= cfg_data[NODE_W-1:0];
                REG_FULL_SPEED:   full_speed_reg   <= cfg_data[15:0];
                REG_STEP_SCALE:   step_scale_reg   <= cfg_data[31:0];
                default:          enable_reg       <= enable_reg;
            endcase
        end
    end

    // alias table
    logic [ENTRY_W-1:0]       entry_mem [ALIAS_ENTRIES];
    logic [ENTRY_W-1:0]       rd_entry_reg;
    logic [IDX_W-1:0]         rd_addr;
    logic                     mem_we;
    logic [IDX_W-1:0]         mem_waddr;
    logic [ENTRY_W-1:0]       mem_wdata;
    logic [ALIAS_ENTRIES-1:0] valid_reg;
    logic [ALIAS_ENTRIES-1:0] valid_next;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        rd_entry_reg <= entry_mem[rd_addr];
    end

    // sequencer and datapath registers
    state_t            state_reg, state_next;
    in_item_t          item_reg, item_next;
    logic [ALIAS_W-1:0] key_reg, key_next;
    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic [CNT_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  found_idx_reg, found_idx_next;
    logic [NODE_W-1:0] node_reg, node_next;
    logic              free_found_reg, free_found_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    logic              accept;
    logic              needs_scan;
    logic              scan_last;
    logic              fin_go;
    logic              hit;
    logic [MAG_W-1:0]  dec_mag;
    logic [MAG_W-1:0]  mag_lim;
    logic [15:0]       mul_b;
    logic [39:0]       prod;
    logic [ACC_W:0]    round_sum;
    logic [20:0]       step_wide;
    logic [6:0]        step;
    logic              is_nan;
    logic              train_ok;
    logic              cmd_ok;
    out_item_t         result;

    assign accept    = in_valid && in_ready;
    assign scan_last = cmp_vld_reg && (cmp_idx_reg == LAST_IDX);
    assign hit       = cmp_vld_reg && valid_reg[cmp_idx_reg]
                       && (rd_entry_reg[ENTRY_W-1:NODE_W] == key_reg);

    always_comb
    begin
        needs_scan = 1'b0;
        case (in_data.cmd)
            CMD_ALIAS_DEF:   needs_scan = (in_data.payload_length >= MIN_LEN_DEF);
            CMD_ALIAS_RESET: needs_scan = 1'b1;
            CMD_TRACTION:    needs_scan = enable_reg
                                          && (in_data.payload_length >= MIN_LEN_CMD);
            default:         needs_scan = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = needs_scan ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_MUL_LO;
                end
            end
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready = 1'b0;
        fin_go   = 1'b0;
        case (state_reg)
            ST_IDLE:   in_ready = 1'b1;
            ST_FINISH: fin_go   = !out_valid_reg || out_ready;
            default:   in_ready = 1'b0;
        endcase
    end

    // speed scaling through one shared 24x16 multiplier
    assign mul_b     = (state_reg == ST_MUL_HI) ? step_scale_reg[31:16]
                                                : step_scale_reg[15:0];
    assign prod      = mag_reg * mul_b;
    assign round_sum = {1'b0, acc_reg} + ROUND_BIAS;
    assign step_wide = round_sum[ACC_W:36];
    assign step      = (step_wide > 21'(MAX_STEP)) ? MAX_STEP : step_wide[6:0];

    assign dec_mag = half_mag(in_data.speed_half);
    assign mag_lim = {full_speed_reg, 8'b0};

    assign is_nan   = (item_reg.speed_half[14:10] == EXP_SPECIAL)
                      && (item_reg.speed_half[9:0] != 10'd0);
    assign train_ok = ((node_reg & PREFIX_MASK) == train_prefix_reg)
                      && (node_reg[13:0] != 14'd0);
    assign cmd_ok   = (item_reg.cmd == CMD_TRACTION) && enable_reg
                      && (item_reg.payload_length >= MIN_LEN_CMD)
                      && found_reg && train_ok;

    always_comb
    begin
        result = '0;
        if (cmd_ok)
        begin
            case (item_reg.operation)
                OP_SPEED:
                begin
                    if ((item_reg.payload_length >= MIN_LEN_SPEED) && !is_nan)
                    begin
                        result.handled     = 1'b1;
                        result.action      = ACT_SPEED;
                        result.dcc_address = node_reg[13:0];
                        result.speed_step  = step;
                        result.forward     = !item_reg.speed_half[15];
                    end
                end
                OP_FUNCTION:
                begin
                    if (item_reg.payload_length >= MIN_LEN_FUNC)
                    begin
                        result.handled     = 1'b1;
                        result.dcc_address = node_reg[13:0];
                        if (item_reg.function_number <= MAX_FUNCTION)
                        begin
                            result.action         = ACT_FUNCTION;
                            result.function_index = item_reg.function_number[4:0];
                            result.function_on    = (item_reg.function_value != 16'd0);
                        end
                    end
                end
                OP_ESTOP:
                begin
                    result.handled     = 1'b1;
                    result.action      = ACT_ESTOP;
                    result.dcc_address = node_reg[13:0];
                    result.forward     = 1'b1;
                end
                default:
                begin
                    result = '0;
                end
            endcase
        end
    end

    // datapath next values
    always_comb
    begin
        item_next       = item_reg;
        key_next        = key_reg;
        mag_next        = mag_reg;
        scan_cnt_next   = scan_cnt_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        node_next       = node_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        acc_next        = acc_reg;
        valid_next      = valid_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        rd_addr         = scan_cnt_reg[IDX_W-1:0];
        mem_we          = 1'b0;
        mem_waddr       = found_idx_reg;
        mem_wdata       = {key_reg, item_reg.node_id};

        if (accept)
        begin
            item_next       = in_data;
            key_next        = (in_data.cmd == CMD_TRACTION) ? in_data.dest_alias
                                                            : in_data.source_alias;
            mag_next        = (dec_mag > mag_lim) ? mag_lim : dec_mag;
            scan_cnt_next   = '0;
            found_next      = 1'b0;
            free_found_next = 1'b0;
        end

        if (state_reg == ST_SCAN)
        begin
            if (scan_cnt_reg < ENTRY_COUNT)
            begin
                cmp_vld_next  = 1'b1;
                cmp_idx_next  = scan_cnt_reg[IDX_W-1:0];
                scan_cnt_next = scan_cnt_reg + CNT_W'(1);
            end
            // compare stage, in the cycle after the read address is given
            if (hit && !found_reg)
            begin
                found_next     = 1'b1;
                found_idx_next = cmp_idx_reg;
                node_next      = rd_entry_reg[NODE_W-1:0];
            end
            if (cmp_vld_reg && !valid_reg[cmp_idx_reg] && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = cmp_idx_reg;
            end
        end

        if (state_reg == ST_MUL_LO)
        begin
            acc_next = {16'b0, prod};
        end
        else if (state_reg == ST_MUL_HI)
        begin
            acc_next = acc_reg + {prod, 16'b0};
        end

        if (fin_go)
        begin
            out_valid_next = 1'b1;
            out_data_next  = result;
            if ((item_reg.cmd == CMD_ALIAS_DEF)
                && (item_reg.payload_length >= MIN_LEN_DEF))
            begin
                if (found_reg)
                begin
                    mem_we = 1'b1;
                end
                else if (free_found_reg)
                begin
                    mem_we                   = 1'b1;
                    mem_waddr                = free_idx_reg;
                    valid_next[free_idx_reg] = 1'b1;
                end
            end
            else if ((item_reg.cmd == CMD_ALIAS_RESET) && found_reg)
            begin
                valid_next[found_idx_reg] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_cnt_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_cnt_reg   <= scan_cnt_next;
            cmp_vld_reg    <= cmp_vld_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        key_reg       <= key_next;
        mag_reg       <= mag_next;
        cmp_idx_reg   <= cmp_idx_next;
        found_idx_reg <= found_idx_next;
        node_reg      <= node_next;
        free_idx_reg  <= free_idx_next;
        acc_reg       <= acc_next;
        out_data_reg  <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // checks
    a_unhandled_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.handled
        |-> out_data.action == ACT_NONE && out_data.dcc_address == 14'd0)
        else $error("unhandled result carries an action or address");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.speed_step <= MAX_STEP)
        else $error("speed step above maximum");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready while a transaction is in progress");

    a_finish_waits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINISH && out_valid_reg && !out_ready
        |=> state_reg == ST_FINISH && out_valid_reg)
        else $error("result overwritten while output stalled");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the traction command to DCC bridge against a local predictor of its
// alias table and command decode. Directed cases come first, then random
// traffic under several register settings, then a long output stall.
// ----------------------------------------------------------------------------
module tb_top
    import tcdb_pkg::*;
();

    localparam int TABLE_DEPTH = ALIAS_ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 250;
    localparam int POOL_SIZE   = 20;
    localparam int MAX_REPORTS = 10;
    localparam logic [NODE_W-1:0] DIRECTED_PREFIX = 48'h0501_0101_0000;
    localparam logic [NODE_W-1:0] FOREIGN_PREFIX  = 48'h0902_0A0B_0000;
    localparam logic [7:0] OP_UNKNOWN_LOW  = 8'd3;
    localparam logic [7:0] OP_UNKNOWN_HIGH = 8'hFF;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    in_item_t in_data;
    logic out_valid;
    logic out_ready;
    out_item_t out_data;

    // predictor state
    logic              alias_used [TABLE_DEPTH];
    logic [ALIAS_W-1:0] alias_key [TABLE_DEPTH];
    logic [NODE_W-1:0]  alias_node [TABLE_DEPTH];
    logic               cfg_enable;
    logic [NODE_W-1:0]  cfg_prefix;
    logic [15:0]        cfg_full_speed;
    logic [31:0]        cfg_step_scale;

    out_item_t pending_results [$];
    logic [ALIAS_W-1:0] alias_pool [POOL_SIZE];

    bit no_gaps;
    int stall_request;
    int items_sent;
    int results_seen;
    int mismatch_count;
    int unexpected_count;
    int settings_applied;
    int speed_count;
    int function_count;
    int stop_count;
    int rejected_count;

    traction_command_to_dcc_bridge #(
        .ALIAS_ENTRIES (TABLE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic void bridge_reset();
        int i;
        cfg_enable     = 1'b0;
        cfg_prefix     = '0;
        cfg_full_speed = FULL_SPEED_RESET;
        cfg_step_scale = STEP_SCALE_RESET;
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            alias_used[i] = 1'b0;
            alias_key[i]  = '0;
            alias_node[i] = '0;
        end
    endfunction

    function automatic int lookup_alias(logic [ALIAS_W-1:0] key);
        int i;
        for (i = 0; i < TABLE_DEPTH; i++)
            if (alias_used[i] && alias_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic void store_alias(logic [ALIAS_W-1:0] key, logic [NODE_W-1:0] node);
        int i;
        i = lookup_alias(key);
        if (i >= 0)
        begin
            alias_node[i] = node;
            return;
        end
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            if (!alias_used[i])
            begin
                alias_used[i] = 1'b1;
                alias_key[i]  = key;
                alias_node[i] = node;
                return;
            end
        end
        // table full: definition dropped
    endfunction

    // half float magnitude to unsigned Q8.16, truncating, saturating
    function automatic logic [23:0] half_to_q8_16(logic [15:0] h);
        logic [4:0]  ex;
        logic [10:0] mant;
        logic [39:0] wide;
        ex   = h[14:10];
        mant = {1'b1, h[9:0]};
        if (ex == 5'd0)
            return {22'd0, h[9:8]};
        if (ex >= 5'd23)
            return 24'hFF_FFFF;
        if (ex >= 5'd9)
        begin
            wide = {29'd0, mant} << (ex - 5'd9);
            return (wide > 40'hFF_FFFF) ? 24'hFF_FFFF : wide[23:0];
        end
        return {13'd0, mant} >> (5'd9 - ex);
    endfunction

    function automatic out_item_t bridge_predict(in_item_t it);
        out_item_t r;
        int slot;
        logic [NODE_W-1:0] dn;
        logic [13:0] addr;
        logic [23:0] mag;
        logic [23:0] lim;
        logic [63:0] prod;
        r = '0;
        case (it.cmd)
            CMD_ALIAS_DEF:
            begin
                if (it.payload_length >= MIN_LEN_DEF)
                    store_alias(it.source_alias, it.node_id);
            end
            CMD_ALIAS_RESET:
            begin
                slot = lookup_alias(it.source_alias);
                if (slot >= 0)
                    alias_used[slot] = 1'b0;
            end
            CMD_TRACTION:
            begin
                slot = (cfg_enable && it.payload_length >= MIN_LEN_CMD)
                       ? lookup_alias(it.dest_alias) : -1;
                if (slot >= 0)
                begin
                    dn   = alias_node[slot];
                    addr = dn[13:0];
                    if ((dn & PREFIX_MASK) == cfg_prefix && addr != 14'd0)
                    begin
                        case (it.operation)
                            OP_SPEED:
                            begin
                                if (it.payload_length >= MIN_LEN_SPEED &&
                                    !(it.speed_half[14:10] == 5'h1F && it.speed_half[9:0] != 0))
                                begin
                                    mag = half_to_q8_16(it.speed_half);
                                    lim = {cfg_full_speed, 8'h00};
                                    if (mag > lim)
                                        mag = lim;
                                    prod = 64'(mag) * 64'(cfg_step_scale) + (64'd1 << 35);
                                    prod = prod >> 36;
                                    r.handled     = 1'b1;
                                    r.action      = ACT_SPEED;
                                    r.dcc_address = addr;
                                    r.speed_step  = (prod > 64'(MAX_STEP)) ? MAX_STEP : prod[6:0];
                                    r.forward     = ~it.speed_half[15];
                                end
                            end
                            OP_FUNCTION:
                            begin
                                if (it.payload_length >= MIN_LEN_FUNC)
                                begin
                                    r.handled     = 1'b1;
                                    r.dcc_address = addr;
                                    if (it.function_number <= MAX_FUNCTION)
                                    begin
                                        r.action         = ACT_FUNCTION;
                                        r.function_index = it.function_number[4:0];
                                        r.function_on    = (it.function_value != 16'd0);
                                    end
                                end
                            end
                            OP_ESTOP:
                            begin
                                r.handled     = 1'b1;
                                r.action      = ACT_ESTOP;
                                r.dcc_address = addr;
                                r.forward     = 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic logic [31:0] scale_for(logic [15:0] fs);
        logic [63:0] q;
        q = (64'd126 << 28) / 64'(fs);
        return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic in_item_t random_fill();
        in_item_t it;
        it.cmd             = 2'($urandom);
        it.payload_length  = 4'($urandom);
        it.source_alias    = 12'($urandom);
        it.node_id         = {16'($urandom), 32'($urandom)};
        it.dest_alias      = 12'($urandom);
        it.operation       = 8'($urandom);
        it.speed_half      = 16'($urandom);
        it.function_number = 24'($urandom);
        it.function_value  = 16'($urandom);
        return it;
    endfunction

    function automatic logic [NODE_W-1:0] train_node();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 8)
            return {cfg_prefix[47:16], 16'($urandom)};
        if (pick == 8)
            return {cfg_prefix[47:16], 2'($urandom), 14'd0};
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [15:0] random_speed();
        if ($urandom_range(0, 9) < 4)
            return 16'($urandom);
        return {1'($urandom), 5'($urandom_range(8, 22)), 10'($urandom)};
    endfunction

    function automatic in_item_t random_traffic();
        in_item_t it;
        int pick;
        it   = random_fill();
        pick = $urandom_range(0, 99);
        if (pick < 18)
        begin
            it.cmd            = CMD_ALIAS_DEF;
            it.source_alias   = alias_pool[$urandom_range(0, POOL_SIZE-1)];
            it.node_id        = train_node();
            it.payload_length = ($urandom_range(0, 9) == 0) ? 4'($urandom)
                                                             : 4'($urandom_range(6, 8));
        end
        else if (pick < 26)
        begin
            it.cmd          = CMD_ALIAS_RESET;
            it.source_alias = alias_pool[$urandom_range(0, POOL_SIZE-1)];
        end
        else if (pick < 94)
        begin
            it.cmd = CMD_TRACTION;
            if ($urandom_range(0, 9) != 0)
                it.dest_alias = alias_pool[$urandom_range(0, POOL_SIZE-1)];
            if ($urandom_range(0, 9) != 0)
                it.operation = 8'($urandom_range(0, 2));
            it.payload_length = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'd8;
            it.speed_half     = random_speed();
            if ($urandom_range(0, 4) != 0)
                it.function_number = 24'($urandom_range(0, 31));
            if ($urandom_range(0, 2) == 0)
                it.function_value = 16'd0;
        end
        else
        begin
            it.cmd = CMD_UNUSED;
        end
        return it;
    endfunction

    // called right after the previous acceptance so valid can stay high
    task automatic send_item(input in_item_t it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        pending_results.push_back(bridge_predict(it));
        items_sent++;
    endtask

    task automatic send_define(input logic [ALIAS_W-1:0] key, input logic [NODE_W-1:0] node,
                               input logic [3:0] len);
        in_item_t it;
        it                = random_fill();
        it.cmd            = CMD_ALIAS_DEF;
        it.source_alias   = key;
        it.node_id        = node;
        it.payload_length = len;
        send_item(it);
    endtask

    task automatic send_release(input logic [ALIAS_W-1:0] key);
        in_item_t it;
        it              = random_fill();
        it.cmd          = CMD_ALIAS_RESET;
        it.source_alias = key;
        send_item(it);
    endtask

    task automatic send_command(input logic [ALIAS_W-1:0] key, input logic [7:0] op,
                                input logic [3:0] len, input logic [15:0] half,
                                input logic [23:0] fnum, input logic [15:0] fval);
        in_item_t it;
        it                 = random_fill();
        it.cmd             = CMD_TRACTION;
        it.dest_alias      = key;
        it.operation       = op;
        it.payload_length  = len;
        it.speed_half      = half;
        it.function_number = fnum;
        it.function_value  = fval;
        send_item(it);
    endtask

    task automatic send_speed(input logic [ALIAS_W-1:0] key, input logic [15:0] half,
                              input logic [3:0] len);
        send_command(key, OP_SPEED, len, half, 24'($urandom), 16'($urandom));
    endtask

    task automatic send_function(input logic [ALIAS_W-1:0] key, input logic [23:0] fnum,
                                 input logic [15:0] fval, input logic [3:0] len);
        send_command(key, OP_FUNCTION, len, 16'($urandom), fnum, fval);
    endtask

    task automatic send_op(input logic [ALIAS_W-1:0] key, input logic [7:0] op,
                           input logic [3:0] len);
        send_command(key, op, len, 16'($urandom), 24'($urandom), 16'($urandom));
    endtask

    // drop valid in the step of the last acceptance and let results drain
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ENABLE:       cfg_enable     = value[0];
            REG_TRAIN_PREFIX: cfg_prefix     = value;
            REG_FULL_SPEED:   cfg_full_speed = value[15:0];
            REG_STEP_SCALE:   cfg_step_scale = value[31:0];
            default:          ;
        endcase
    endtask

    task automatic apply_settings(input logic [NODE_W-1:0] prefix, input logic [15:0] fs,
                                  input logic [31:0] scale);
        wait_for_results();
        write_reg(REG_TRAIN_PREFIX, prefix);
        write_reg(REG_FULL_SPEED, {32'd0, fs});
        write_reg(REG_STEP_SCALE, {16'd0, scale});
        settings_applied++;
    endtask

    task automatic run_traffic(input int count);
        repeat (count) send_item(random_traffic());
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed_cases();
        // disabled block ignores traction commands
        send_define(12'h001, DIRECTED_PREFIX | 48'h0003, 4'd6);
        send_speed(12'h001, 16'h3C00, 4'd8);
        wait_for_results();
        write_reg(REG_ENABLE, 48'd1);
        write_reg(REG_TRAIN_PREFIX, DIRECTED_PREFIX);
        send_define(12'h002, DIRECTED_PREFIX | 48'h0004, 4'd5);
        send_op(12'h002, OP_ESTOP, 4'd8);
        send_op(12'h001, OP_ESTOP, 4'd3);
        send_op(12'h001, OP_ESTOP, 4'd2);
        // speed decode corners: zeros, subnormal, max finite, infinities, nan
        send_speed(12'h001, 16'h0000, 4'd5);
        send_speed(12'h001, 16'h8000, 4'd5);
        send_speed(12'h001, 16'h03FF, 4'd8);
        send_speed(12'h001, 16'h3C00, 4'd8);
        send_speed(12'h001, 16'hBC00, 4'd8);
        send_speed(12'h001, 16'h7BFF, 4'd8);
        send_speed(12'h001, 16'h7C00, 4'd8);
        send_speed(12'h001, 16'hFC00, 4'd8);
        send_speed(12'h001, 16'h7E00, 4'd8);
        send_speed(12'h001, 16'hFFFF, 4'd8);
        send_speed(12'h001, 16'h3C00, 4'd4);
        send_function(12'h001, 24'd0, 16'd1, 4'd8);
        send_function(12'h001, 24'd28, 16'hFFFF, 4'd8);
        send_function(12'h001, 24'd29, 16'd1, 4'd8);
        send_function(12'h001, 24'hFF_FFFF, 16'd0, 4'd15);
        send_function(12'h001, 24'd5, 16'd1, 4'd7);
        send_op(12'h001, OP_UNKNOWN_LOW, 4'd8);
        send_op(12'h001, OP_UNKNOWN_HIGH, 4'd8);
        begin
            in_item_t it;
            it     = random_fill();
            it.cmd = CMD_UNUSED;
            send_item(it);
        end
        wait_for_results();
    endtask

    task automatic test_alias_table();
        int k;
        // zero address, foreign node and widest address
        send_define(12'hFFF, DIRECTED_PREFIX, 4'd6);
        send_op(12'hFFF, OP_ESTOP, 4'd8);
        send_define(12'h000, FOREIGN_PREFIX | 48'h0007, 4'd8);
        send_op(12'h000, OP_ESTOP, 4'd8);
        send_define(12'h7FF, DIRECTED_PREFIX | 48'hFFFF, 4'd7);
        send_op(12'h7FF, OP_ESTOP, 4'd8);
        // four entries held, fill the rest
        for (k = 0; k < TABLE_DEPTH - 4; k++)
            send_define(12'h100 + 12'(k), DIRECTED_PREFIX | 48'(k + 16), 4'd6);
        send_define(12'h0AB, DIRECTED_PREFIX | 48'h0055, 4'd6);
        send_op(12'h0AB, OP_ESTOP, 4'd8);
        send_define(12'h001, DIRECTED_PREFIX | 48'h0123, 4'd6);
        send_op(12'h001, OP_ESTOP, 4'd8);
        send_release(12'h0AB);
        send_op(12'h100, OP_ESTOP, 4'd8);
        send_release(12'h100);
        send_op(12'h100, OP_ESTOP, 4'd8);
        send_define(12'h0AB, DIRECTED_PREFIX | 48'h0055, 4'd6);
        send_function(12'h0AB, 24'd13, 16'h8000, 4'd8);
        // leave the table empty for random traffic
        send_release(12'h001);
        send_release(12'hFFF);
        send_release(12'h000);
        send_release(12'h7FF);
        send_release(12'h0AB);
        for (k = 1; k < TABLE_DEPTH - 4; k++)
            send_release(12'h100 + 12'(k));
        wait_for_results();
    endtask

    task automatic test_register_sweep();
        logic [15:0] fs;
        apply_settings({16'($urandom), 16'($urandom), 16'h0000}, FULL_SPEED_RESET,
                       STEP_SCALE_RESET);
        run_traffic(190);
        no_gaps = 1'b1;
        apply_settings(cfg_prefix, 16'd26, scale_for(16'd26));
        run_traffic(190);
        no_gaps = 1'b0;
        apply_settings(cfg_prefix, 16'hFFFF, 32'hFFFF_FFFF);
        run_traffic(190);
        apply_settings('0, 16'hFFFF, 32'd1);
        run_traffic(190);
        fs = 16'($urandom_range(26, 65535));
        apply_settings(PREFIX_MASK, fs, scale_for(fs));
        run_traffic(190);
        wait_for_results();
        write_reg(REG_ENABLE, 48'd0);
        run_traffic(80);
        wait_for_results();
        write_reg(REG_ENABLE, 48'd1);
        // low bits set: no node can match
        apply_settings(48'hFFFF_FFFF_FFFF, 16'd10240, STEP_SCALE_RESET);
        run_traffic(40);
        fs = 16'($urandom_range(26, 65535));
        apply_settings({16'($urandom), 16'($urandom), 16'h0000}, fs,
                       $urandom_range(1, 32'hFFFF_FFFF));
        run_traffic(150);
        wait_for_results();
    endtask

    task automatic test_output_stall();
        no_gaps       = 1'b1;
        stall_request = HOLD_CYCLES;
        run_traffic(48);
        no_gaps = 1'b0;
        wait_for_results();
    endtask

    // ------------------------------------------------------------------------
    // result receiver with random pauses and the long hold
    // ------------------------------------------------------------------------
    initial
    begin
        int pause_left;
        int hold_left;
        pause_left = 0;
        hold_left  = 0;
        out_ready  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready)
                pause_left = no_gaps ? 0 : $urandom_range(0, 5);
            else if (pause_left > 0)
                pause_left--;
            if (stall_request > 0)
            begin
                hold_left     = stall_request;
                stall_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= (pause_left == 0);
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                unexpected_count++;
                if (unexpected_count <= MAX_REPORTS)
                    $display("unexpected result transaction: handled=%0d action=%0d",
                             out_data.handled, out_data.action);
            end
            else
            begin
                want = pending_results.pop_front();
                results_seen++;
                case (want.action)
                    ACT_SPEED:    speed_count++;
                    ACT_FUNCTION: function_count++;
                    ACT_ESTOP:    stop_count++;
                    default:      if (!want.handled) rejected_count++;
                endcase
                if (out_data.handled !== want.handled ||
                    out_data.action !== want.action ||
                    out_data.dcc_address !== want.dcc_address ||
                    out_data.speed_step !== want.speed_step ||
                    out_data.forward !== want.forward ||
                    out_data.function_index !== want.function_index ||
                    out_data.function_on !== want.function_on)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("mismatch on result %0d at %0t", results_seen, $realtime);
                        $display(
                            "  expected h=%0d act=%0d addr=%0d step=%0d fwd=%0d fn=%0d on=%0d",
                            want.handled, want.action, want.dcc_address, want.speed_step,
                            want.forward, want.function_index, want.function_on);
                        $display(
                            "  actual   h=%0d act=%0d addr=%0d step=%0d fwd=%0d fn=%0d on=%0d",
                            out_data.handled, out_data.action, out_data.dcc_address,
                            out_data.speed_step, out_data.forward, out_data.function_index,
                            out_data.function_on);
                    end
                end
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
                 pending_results.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int k;
        int failures;
        cfg_we           = 1'b0;
        cfg_index        = REG_ENABLE;
        cfg_data         = '0;
        in_valid         = 1'b0;
        in_data          = '0;
        rst_n            = 1'b0;
        no_gaps          = 1'b0;
        stall_request    = 0;
        items_sent       = 0;
        results_seen     = 0;
        mismatch_count   = 0;
        unexpected_count = 0;
        settings_applied = 0;
        speed_count      = 0;
        function_count   = 0;
        stop_count       = 0;
        rejected_count   = 0;
        bridge_reset();
        alias_pool[0] = 12'h000;
        alias_pool[1] = 12'hFFF;
        for (k = 2; k < POOL_SIZE; k++)
            alias_pool[k] = 12'($urandom);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_alias_table();
        test_register_sweep();
        test_output_stall();

        wait_for_results();
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        failures = mismatch_count + unexpected_count + pending_results.size();
        $display("%0d transactions in, %0d results checked over %0d register settings",
                 items_sent, results_seen, settings_applied);
        $display("speed %0d, function %0d, stop %0d, not handled %0d, mismatches %0d",
                 speed_count, function_count, stop_count, rejected_count, mismatch_count);
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
